FILE: design/fecc_pkg.sv
// Shared types, constants and helper functions of the flash ECC image word encoder.
package fecc_pkg;

    // Field and address widths
    localparam int LA_BITS     = 24;
    localparam int IDX_BITS    = 23;
    localparam int LEN_BITS    = 25;
    localparam int PA_BITS     = 25;
    localparam int WORD_BITS   = 32;
    localparam int ECC_BITS    = 7;
    localparam int STATUS_BITS = 3;
    localparam int GRP_BITS    = 20;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    // Queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

    // Divide by three: x / 3 == (x * DIV3_MUL) >> DIV3_SHIFT for x up to 2**21
    localparam logic [21:0] DIV3_MUL   = 22'h2AAAAB;
    localparam int          DIV3_SHIFT = 23;

    // Word index saturation
    localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISALIGNED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_END_BEYOND = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BEGIN_GT   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_LEN_MISM   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_OVERRUN    = 3'd5;

    // Register indexes
    localparam logic [1:0] REG_REGION_BEGIN = 2'd0;
    localparam logic [1:0] REG_REGION_END   = 2'd1;
    localparam logic [1:0] REG_PART_LENGTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_LENGTH = 2'd3;

    // Register reset values
    localparam logic [LA_BITS-1:0]  RST_REGION_BEGIN = 24'd0;
    localparam logic [LA_BITS-1:0]  RST_REGION_END   = 24'd7;
    localparam logic [LEN_BITS-1:0] RST_PART_LENGTH  = 25'd8;
    localparam logic [LEN_BITS-1:0] RST_IMAGE_LENGTH = 25'd32;

    // Parity masks, mask i produces ECC bit i
    localparam logic [ECC_BITS-1:0][WORD_BITS-1:0] ECC_MASK = {
        32'hff0000ff, 32'hff00ff00, 32'hc0fcc0fc, 32'h38e338e3,
        32'ha699a699, 32'h15571557, 32'h4b2e4b2e
    };

    // Configuration seen by both halves
    typedef struct packed {
        logic [LA_BITS-1:0]  region_begin;
        logic [LA_BITS-1:0]  region_end;
        logic [LEN_BITS-1:0] part_length;
        logic [LEN_BITS-1:0] image_length;
    } cfg_t;

    // Classified word travelling from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0]   data_word;
        logic [LA_BITS-1:0]     la;
        logic [STATUS_BITS-1:0] status;
    } entry_t;

    // Seven parity bits of a word
    function automatic logic [ECC_BITS-1:0] ecc_of(input logic [WORD_BITS-1:0] w);
        logic [ECC_BITS-1:0] e;
        e = '0;
        for (int i = 0; i < ECC_BITS; i++)
        begin
            e[i] = ^(w & ECC_MASK[i]);
        end
        return e;
    endfunction

endpackage

FILE: design/flash_ecc_image_word_encoder_core.sv
// Top level of the flash ECC image word encoder: front, queue and back joined.
// An accepted word passes through the queue, stage 1 and the result register to the output
// ports; one word per cycle is sustained while results are popped.
// The queue holds four classified words, so the front keeps accepting while results wait, until the queue is full.
// Reset (rst_n low, asynchronous) restores register defaults, clears the word counter,
// empties the queue and drops all pending results.
module flash_ecc_image_word_encoder_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fecc_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [fecc_pkg::DATA_BITS-1:0]       pwdata,
    output logic [fecc_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready,
    // input words
    input  logic                                 push,
    output logic                                 full,
    input  logic [fecc_pkg::WORD_BITS-1:0]       data_word,
    // results
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 write_enable,
    output logic [fecc_pkg::PA_BITS-1:0]         phys_addr,
    output logic [fecc_pkg::WORD_BITS-1:0]       stored_word,
    output logic [fecc_pkg::ECC_BITS-1:0]        ecc_byte,
    output logic                                 pad_block,
    output logic [fecc_pkg::STATUS_BITS-1:0]     status
);

    fecc_pkg::cfg_t    cfg;
    fecc_pkg::entry_t  wr_entry;
    fecc_pkg::entry_t  rd_entry;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    assign full = q_full;

    fecc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .data_word (data_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (wr_entry),
        .cfg       (cfg)
    );

    fecc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .rd       (q_pop),
        .rd_entry (rd_entry),
        .empty    (q_empty)
    );

    fecc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_entry      (rd_entry),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .write_enable (write_enable),
        .phys_addr    (phys_addr),
        .stored_word  (stored_word),
        .ecc_byte     (ecc_byte),
        .pad_block    (pad_block),
        .status       (status)
    );

endmodule

FILE: design/fecc_front.sv
// Front half: configuration registers, word counter and per-word status classification.
module fecc_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fecc_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [fecc_pkg::DATA_BITS-1:0]      pwdata,
    output logic [fecc_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    // input words
    input  logic                                push,
    input  logic [fecc_pkg::WORD_BITS-1:0]      data_word,
    input  logic                                q_full,
    output logic                                q_push,
    output fecc_pkg::entry_t                    q_entry,
    // configuration for the back half
    output fecc_pkg::cfg_t                      cfg
);

    logic [fecc_pkg::LA_BITS-1:0]  region_begin_reg, region_begin_next;
    logic [fecc_pkg::LA_BITS-1:0]  region_end_reg, region_end_next;
    logic [fecc_pkg::LEN_BITS-1:0] part_length_reg, part_length_next;
    logic [fecc_pkg::LEN_BITS-1:0] image_length_reg, image_length_next;
    logic [fecc_pkg::IDX_BITS-1:0] word_index_reg, word_index_next;

    logic                          wr_en;
    logic                          take;
    logic [fecc_pkg::LEN_BITS-1:0] end_plus1;
    logic [fecc_pkg::GRP_BITS-1:0] il_grp;
    logic [2:0]                    il_slot;
    logic [fecc_pkg::LEN_BITS:0]   log_cap;
    logic [fecc_pkg::LEN_BITS-1:0] span;
    logic [fecc_pkg::LEN_BITS-1:0] byte_off;
    logic [fecc_pkg::STATUS_BITS-1:0] status;

    // Slot of a physical offset within a 32-byte block (offset / 5)
    function automatic logic [2:0] slot_of(input logic [4:0] off);
        logic [2:0] s;
        if (off >= 5'd30)
            s = 3'd6;
        else if (off >= 5'd25)
            s = 3'd5;
        else if (off >= 5'd20)
            s = 3'd4;
        else if (off >= 5'd15)
            s = 3'd3;
        else if (off >= 5'd10)
            s = 3'd2;
        else if (off >= 5'd5)
            s = 3'd1;
        else
            s = 3'd0;
        return s;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign take   = push & ~q_full;

    // Decode register writes
    always_comb
    begin
        region_begin_next = region_begin_reg;
        region_end_next   = region_end_reg;
        part_length_next  = part_length_reg;
        image_length_next = image_length_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                fecc_pkg::REG_REGION_BEGIN: region_begin_next = pwdata[fecc_pkg::LA_BITS-1:0];
                fecc_pkg::REG_REGION_END:   region_end_next   = pwdata[fecc_pkg::LA_BITS-1:0];
                fecc_pkg::REG_PART_LENGTH:  part_length_next  = pwdata[fecc_pkg::LEN_BITS-1:0];
                fecc_pkg::REG_IMAGE_LENGTH: image_length_next = pwdata[fecc_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        case (paddr[3:2])
            fecc_pkg::REG_REGION_BEGIN: prdata = fecc_pkg::DATA_BITS'(region_begin_reg);
            fecc_pkg::REG_REGION_END:   prdata = fecc_pkg::DATA_BITS'(region_end_reg);
            fecc_pkg::REG_PART_LENGTH:  prdata = fecc_pkg::DATA_BITS'(part_length_reg);
            fecc_pkg::REG_IMAGE_LENGTH: prdata = fecc_pkg::DATA_BITS'(image_length_reg);
            default:                    prdata = '0;
        endcase
    end

    // Clear the counter on any register write, else advance and saturate per transfer
    always_comb
    begin
        word_index_next = word_index_reg;
        if (wr_en)
            word_index_next = '0;
        else if (take && word_index_reg != fecc_pkg::IDX_MAX)
            word_index_next = word_index_reg + 1'b1;
    end

    // Logical capacity of the image: 24 bytes per block plus 4 per whole slot
    assign il_grp    = image_length_reg[fecc_pkg::LEN_BITS-1:5];
    assign il_slot   = slot_of(image_length_reg[4:0]);
    assign log_cap   = {2'b00, il_grp, 4'b0000} + {3'b000, il_grp, 3'b000}
                     + {21'd0, il_slot, 2'b00};
    assign end_plus1 = {1'b0, region_end_reg} + 25'd1;
    assign span      = {1'b0, region_end_reg} - {1'b0, region_begin_reg} + 25'd1;
    assign byte_off  = {word_index_reg, 2'b00};

    // Classify the word, first failing check wins
    always_comb
    begin
        if (region_begin_reg[2:0] != 3'd0 || region_end_reg[2:0] != 3'd7)
            status = fecc_pkg::ST_MISALIGNED;
        else if ({1'b0, end_plus1} > log_cap)
            status = fecc_pkg::ST_END_BEYOND;
        else if (region_begin_reg > region_end_reg)
            status = fecc_pkg::ST_BEGIN_GT;
        else if (part_length_reg != span)
            status = fecc_pkg::ST_LEN_MISM;
        else if (byte_off >= part_length_reg)
            status = fecc_pkg::ST_OVERRUN;
        else
            status = fecc_pkg::ST_OK;
    end

    assign q_push            = take;
    assign q_entry.data_word = data_word;
    assign q_entry.la        = region_begin_reg + byte_off[fecc_pkg::LA_BITS-1:0];
    assign q_entry.status    = status;

    assign cfg.region_begin  = region_begin_reg;
    assign cfg.region_end    = region_end_reg;
    assign cfg.part_length   = part_length_reg;
    assign cfg.image_length  = image_length_reg;

    // Hold configuration and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_begin_reg <= fecc_pkg::RST_REGION_BEGIN;
            region_end_reg   <= fecc_pkg::RST_REGION_END;
            part_length_reg  <= fecc_pkg::RST_PART_LENGTH;
            image_length_reg <= fecc_pkg::RST_IMAGE_LENGTH;
            word_index_reg   <= '0;
        end
        else
        begin
            region_begin_reg <= region_begin_next;
            region_end_reg   <= region_end_next;
            part_length_reg  <= part_length_next;
            image_length_reg <= image_length_next;
            word_index_reg   <= word_index_next;
        end
    end

endmodule

FILE: design/fecc_queue.sv
// Short queue of classified words between the front and back halves.
module fecc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  fecc_pkg::entry_t  wr_entry,
    output logic              full,
    input  logic              rd,
    output fecc_pkg::entry_t  rd_entry,
    output logic              empty
);

    fecc_pkg::entry_t                  slots [fecc_pkg::Q_DEPTH];
    logic [fecc_pkg::Q_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [fecc_pkg::Q_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [fecc_pkg::Q_CNT_BITS-1:0]   count_reg, count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full     = (count_reg == fecc_pkg::Q_CNT_BITS'(fecc_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_wr    = wr & ~full;
    assign do_rd    = rd & ~empty;
    assign rd_entry = slots[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_entry;
    end

endmodule

FILE: design/fecc_back.sv
// Back half: parity, logical-to-physical mapping, padding decision and result register.
module fecc_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fecc_pkg::cfg_t                       cfg,
    input  logic                                 q_empty,
    input  fecc_pkg::entry_t                     q_entry,
    output logic                                 q_pop,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 write_enable,
    output logic [fecc_pkg::PA_BITS-1:0]         phys_addr,
    output logic [fecc_pkg::WORD_BITS-1:0]       stored_word,
    output logic [fecc_pkg::ECC_BITS-1:0]        ecc_byte,
    output logic                                 pad_block,
    output logic [fecc_pkg::STATUS_BITS-1:0]     status
);

    // Stage 1 registers
    logic                               s1_valid_reg, s1_valid_next;
    logic [fecc_pkg::WORD_BITS-1:0]     s1_word_reg;
    logic [fecc_pkg::LA_BITS-1:0]       s1_la_reg;
    logic [fecc_pkg::STATUS_BITS-1:0]   s1_status_reg;
    logic [fecc_pkg::ECC_BITS-1:0]      s1_ecc_reg;
    logic [fecc_pkg::GRP_BITS-1:0]      s1_grp_reg;
    logic [fecc_pkg::GRP_BITS-1:0]      s1_end_grp_reg;

    // Output registers
    logic                               out_valid_reg, out_valid_next;
    logic                               we_reg;
    logic [fecc_pkg::PA_BITS-1:0]       pa_reg;
    logic [fecc_pkg::WORD_BITS-1:0]     word_reg;
    logic [fecc_pkg::ECC_BITS-1:0]      ecc_reg;
    logic                               pad_reg;
    logic [fecc_pkg::STATUS_BITS-1:0]   status_reg;

    logic                               out_ready;
    logic                               s1_ready;
    logic [fecc_pkg::LEN_BITS-1:0]      end_plus1;
    logic [42:0]                        grp_prod;
    logic [43:0]                        end_prod;
    logic [4:0]                         grp_rem;
    logic [2:0]                         slot;
    logic [fecc_pkg::PA_BITS-1:0]       pa_calc;
    logic                               pad_calc;
    logic                               ok;

    // Flow control: a stage takes a transfer when it is empty or drains this cycle
    assign out_ready = pop | ~out_valid_reg;
    assign s1_ready  = ~s1_valid_reg | out_ready;
    assign q_pop     = ~q_empty & s1_ready;

    assign s1_valid_next  = s1_ready ? q_pop : s1_valid_reg;
    assign out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;

    // Group number of the word and of the partition end (divide by 24 as >>3 then /3)
    assign end_plus1 = {1'b0, cfg.region_end} + 25'd1;
    assign grp_prod  = {22'd0, q_entry.la[fecc_pkg::LA_BITS-1:3]} * {21'd0, fecc_pkg::DIV3_MUL};
    assign end_prod  = {22'd0, end_plus1[fecc_pkg::LEN_BITS-1:3]} * {22'd0, fecc_pkg::DIV3_MUL};

    // Offset inside the 24-byte group, its word slot and the physical address
    assign grp_rem  = s1_la_reg[4:0] - 5'({s1_grp_reg, 3'b000}) - 5'({s1_grp_reg, 4'b0000});
    assign slot     = grp_rem[4:2];
    assign pa_calc  = {s1_grp_reg, 5'b00000} + fecc_pkg::PA_BITS'({slot, 2'b00})
                    + fecc_pkg::PA_BITS'(slot);
    assign pad_calc = (s1_grp_reg < s1_end_grp_reg)
                    && ({s1_grp_reg, 5'b11111} < cfg.image_length);
    assign ok       = (s1_status_reg == fecc_pkg::ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load stage 1 from the queue
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_word_reg    <= q_entry.data_word;
            s1_la_reg      <= q_entry.la;
            s1_status_reg  <= q_entry.status;
            s1_ecc_reg     <= fecc_pkg::ecc_of(q_entry.data_word);
            s1_grp_reg     <= grp_prod[fecc_pkg::DIV3_SHIFT +: fecc_pkg::GRP_BITS];
            s1_end_grp_reg <= end_prod[fecc_pkg::DIV3_SHIFT +: fecc_pkg::GRP_BITS];
        end
    end

    // Load the result register, zero everything but status on an error
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_ready)
        begin
            we_reg     <= ok;
            pa_reg     <= ok ? pa_calc : '0;
            word_reg   <= ok ? s1_word_reg : '0;
            ecc_reg    <= ok ? s1_ecc_reg : '0;
            pad_reg    <= ok & pad_calc;
            status_reg <= s1_status_reg;
        end
    end

    assign empty        = ~out_valid_reg;
    assign write_enable = we_reg;
    assign phys_addr    = pa_reg;
    assign stored_word  = word_reg;
    assign ecc_byte     = ecc_reg;
    assign pad_block    = pad_reg;
    assign status       = status_reg;

endmodule
